[rtl/core/ffpa_pkg.sv]
// Package: constants, codes and entry type for the first-fit partition allocator.
`timescale 1ns / 1ps
package ffpa_pkg;
    localparam int MaxBlocks = 16;
    localparam int AddrBits  = 16;
    localparam int IdxBits   = $clog2(MaxBlocks);
    localparam int CntBits   = $clog2(MaxBlocks + 1);
    localparam int SizeBits  = 16;
    localparam int JobBits   = 8;
    localparam int OpBits    = 2;
    localparam int StatBits  = 2;

    localparam logic [OpBits-1:0] OP_APPEND  = 2'd0;
    localparam logic [OpBits-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OpBits-1:0] OP_RELEASE = 2'd2;
    localparam logic [OpBits-1:0] OP_NOP     = 2'd3;

    localparam logic [StatBits-1:0] ST_OK      = 2'd0;
    localparam logic [StatBits-1:0] ST_NOFIT   = 2'd1;
    localparam logic [StatBits-1:0] ST_NOJOB   = 2'd2;
    localparam logic [StatBits-1:0] ST_FULL    = 2'd3;

    localparam logic [SizeBits-1:0] SplitThresholdReset = 16'd4;

    typedef struct packed {
        logic [AddrBits-1:0] start;
        logic [SizeBits-1:0] size;
        logic                taken;
        logic [JobBits-1:0]  owner;
        logic [SizeBits-1:0] request;
    } t_entry;

    localparam int EntryBits = $bits(t_entry);
endpackage

[rtl/core/first_fit_partition_allocator_core.sv]
// Top level: first-fit partition allocator with a block table held in one RAM.
//
// A command is taken when i_start is high and o_busy is low; exactly one result is
// shown on o_status/o_start_address/o_block_size for one cycle with o_done high and
// must be consumed in that cycle. Append and no-op go from idle straight to the done
// state, which registers o_done. Allocate and release scan the table entry by entry
// through the RAM read port (a scan state issues the address, a check state takes the
// data), then an insert or remove moves each following entry one place with a shift read
// state and a shift write state, and a final write stores the result entry before the
// done state. i_cfg_we may be pulsed while idle.
`timescale 1ns / 1ps
module first_fit_partition_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffpa_pkg::SizeBits-1:0]   i_cfg_wdata,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [ffpa_pkg::OpBits-1:0]     i_opcode,
    input  logic [ffpa_pkg::JobBits-1:0]    i_job_id,
    input  logic [ffpa_pkg::SizeBits-1:0]   i_amount,
    output logic                            o_done,
    output logic [ffpa_pkg::StatBits-1:0]   o_status,
    output logic [ffpa_pkg::AddrBits-1:0]   o_start_address,
    output logic [ffpa_pkg::SizeBits-1:0]   o_block_size
);
    import ffpa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;  // read address issued, data next cycle
    localparam logic [3:0] S_CHECK  = 4'd2;  // examine entry r_idx
    localparam logic [3:0] S_NBR    = 4'd3;  // neighbor read issued
    localparam logic [3:0] S_NBRCHK = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;  // shift read issued
    localparam logic [3:0] S_SHWR   = 4'd6;  // shift write
    localparam logic [3:0] S_FIN    = 4'd7;  // final write
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [SizeBits-1:0] r_thresh;
    logic [CntBits-1:0]  r_count, n_count;
    logic [AddrBits-1:0] r_app, n_app;
    logic [OpBits-1:0]   r_op;
    logic [JobBits-1:0]  r_job;
    logic [SizeBits-1:0] r_amt;
    logic [CntBits-1:0]  r_idx, n_idx;     // found entry / scan pointer
    logic [CntBits-1:0]  r_ptr, n_ptr;     // shift pointer
    t_entry              r_cur, n_cur;     // found entry
    t_entry              r_prv, n_prv;     // previous scanned entry
    logic                r_ins, n_ins;     // shift direction: insert (up by one index) or remove
    t_entry              r_fin, n_fin;     // entry written at r_fin_at at the end
    logic [CntBits-1:0]  r_fin_at, n_fin_at;
    logic [StatBits-1:0] r_st, n_st;
    logic [AddrBits-1:0] r_oa, n_oa;
    logic [SizeBits-1:0] r_os, n_os;
    logic                r_done, n_done;

    logic                we;
    logic [IdxBits-1:0]  waddr, raddr;
    t_entry              wdata, rdata;
    logic [EntryBits-1:0] rbits;

    assign rdata = t_entry'(rbits);

    ffpa_ram #(.Width(EntryBits), .Depth(MaxBlocks)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(EntryBits'(wdata)),
        .i_raddr(raddr),
        .o_rdata(rbits)
    );

    logic [SizeBits:0] sum_prev, sum_next;
    logic [SizeBits-1:0] left;
    assign sum_prev = {1'b0, r_prv.size} + {1'b0, rdata.size};
    assign sum_next = {1'b0, r_cur.size} + {1'b0, rdata.size};
    assign left     = rdata.size - r_amt;

    always_comb begin
        n_state = r_state; n_count = r_count; n_app = r_app; n_idx = r_idx;
        n_ptr = r_ptr; n_cur = r_cur; n_prv = r_prv;
        n_ins = r_ins; n_fin = r_fin; n_fin_at = r_fin_at; n_st = r_st; n_oa = r_oa;
        n_os = r_os; n_done = 1'b0;
        we = 1'b0; waddr = '0; wdata = '0; raddr = r_idx[IdxBits-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_idx = '0; n_st = ST_OK; n_oa = '0; n_os = '0;
                    unique case (i_opcode) inside
                        OP_APPEND: begin
                            if (r_count == CntBits'(MaxBlocks)) begin
                                n_st = ST_FULL;
                            end else begin
                                we = 1'b1; waddr = r_count[IdxBits-1:0];
                                wdata = '{start: r_app, size: i_amount, taken: 1'b0,
                                          owner: '0, request: '0};
                                n_count = r_count + 1'b1;
                                n_app = r_app + AddrBits'(i_amount);
                                n_oa = r_app; n_os = i_amount;
                            end
                            n_state = S_DONE;
                        end
                        OP_ALLOC, OP_RELEASE: n_state = S_SCAN;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_st = (r_op == OP_ALLOC) ? ST_NOFIT : ST_NOJOB;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_prv = rdata;
                n_state = S_SCAN;
                n_idx = r_idx + 1'b1;
                raddr = n_idx[IdxBits-1:0];
                if (r_op == OP_ALLOC) begin
                    if (!rdata.taken && rdata.size >= r_amt) begin
                        n_idx = r_idx; n_cur = rdata;
                        if (left <= r_thresh) begin
                            n_fin = '{start: rdata.start, size: rdata.size, taken: 1'b1,
                                      owner: r_job, request: r_amt};
                            n_fin_at = r_idx;
                            n_oa = rdata.start; n_os = rdata.size;
                            n_state = S_FIN;
                        end else if (r_count == CntBits'(MaxBlocks)) begin
                            n_st = ST_FULL; n_state = S_DONE;
                        end else begin
                            // move entries r_idx..count-1 up by one, top first
                            n_ins = 1'b1; n_ptr = r_count;
                            n_fin = '{start: rdata.start, size: r_amt, taken: 1'b1,
                                      owner: r_job, request: r_amt};
                            n_fin_at = r_idx;
                            n_oa = rdata.start; n_os = r_amt;
                            n_count = r_count + 1'b1;
                            n_state = S_SHRD;
                        end
                    end
                end else if (rdata.taken && rdata.owner == r_job) begin
                    n_idx = r_idx; n_cur = rdata;
                    if (r_idx != '0 && !r_prv.taken &&
                        r_prv.start + AddrBits'(r_prv.size) == rdata.start &&
                        !sum_prev[SizeBits]) begin
                        n_fin = r_prv;
                        n_fin.size = sum_prev[SizeBits-1:0];
                        n_fin_at = r_idx - 1'b1;
                        n_oa = r_prv.start; n_os = n_fin.size;
                        n_ins = 1'b0; n_ptr = r_idx;
                        n_state = (r_idx + 1'b1 == r_count) ? S_FIN : S_SHRD;
                        if (r_idx + 1'b1 == r_count) n_count = r_count - 1'b1;
                    end else if (r_idx + 1'b1 < r_count) begin
                        n_state = S_NBR;
                        raddr = n_idx[IdxBits-1:0] + 1'b1;
                    end else begin
                        n_fin = '{start: rdata.start, size: rdata.size, taken: 1'b0,
                                  owner: '0, request: '0};
                        n_fin_at = r_idx;
                        n_oa = rdata.start; n_os = rdata.size;
                        n_state = S_FIN;
                    end
                end
            end
            S_NBR: begin
                // hold the successor address so its data lands in the check cycle
                raddr = IdxBits'(r_idx + 1'b1);
                n_state = S_NBRCHK;
            end
            S_NBRCHK: begin
                n_fin = '{start: r_cur.start, size: r_cur.size, taken: 1'b0,
                          owner: '0, request: '0};
                n_fin_at = r_idx;
                n_state = S_FIN;
                if (!rdata.taken && r_cur.start + AddrBits'(r_cur.size) == rdata.start &&
                    !sum_next[SizeBits]) begin
                    n_fin.size = sum_next[SizeBits-1:0];
                    n_ins = 1'b0; n_ptr = r_idx + 1'b1;
                    if (r_idx + 2'd2 == r_count) n_count = r_count - 1'b1;
                    else n_state = S_SHRD;
                end
                n_oa = r_cur.start; n_os = n_fin.size;
            end
            S_SHRD: begin
                // insert: read ptr-1; remove: read ptr+1
                raddr = r_ins ? IdxBits'(r_ptr - 1'b1) : IdxBits'(r_ptr + 1'b1);
                n_state = S_SHWR;
            end
            S_SHWR: begin
                we = 1'b1; wdata = rdata;
                if (r_ins) begin
                    waddr = r_ptr[IdxBits-1:0];
                    if (r_ptr - 1'b1 == r_fin_at) begin
                        // the remainder: shrink and advance start
                        wdata.start = rdata.start + AddrBits'(r_amt);
                        wdata.size = rdata.size - r_amt;
                        n_state = S_FIN;
                    end else begin
                        n_ptr = r_ptr - 1'b1; n_state = S_SHRD;
                    end
                end else begin
                    waddr = r_ptr[IdxBits-1:0];
                    n_ptr = r_ptr + 1'b1;
                    if (r_ptr + 2'd2 == r_count) begin
                        n_count = r_count - 1'b1; n_state = S_FIN;
                    end else begin
                        n_state = S_SHRD;
                    end
                end
            end
            S_FIN: begin
                we = 1'b1; waddr = r_fin_at[IdxBits-1:0]; wdata = r_fin;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_done = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_app <= '0;
            r_thresh <= SplitThresholdReset; r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_app <= n_app; r_done <= n_done;
            if (i_cfg_we) r_thresh <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op <= i_opcode; r_job <= i_job_id; r_amt <= i_amount;
        end
        r_idx <= n_idx; r_ptr <= n_ptr; r_cur <= n_cur; r_prv <= n_prv;
        r_ins <= n_ins; r_fin <= n_fin; r_fin_at <= n_fin_at;
        r_st <= n_st; r_oa <= n_oa; r_os <= n_os;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_st;
    assign o_start_address = r_oa;
    assign o_block_size    = r_os;
endmodule

[rtl/core/ffpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ffpa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/ffpa_checker.sv]
// Port-level checker for the first-fit partition allocator, bound to the top level.
`timescale 1ns / 1ps
module ffpa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_done,
    input logic [ffpa_pkg::StatBits-1:0] o_status,
    input logic [ffpa_pkg::AddrBits-1:0] o_start_address,
    input logic [ffpa_pkg::SizeBits-1:0] o_block_size
);
    import ffpa_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("no busy after start");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_start_address == '0 && o_block_size == '0))
        else $error("failed result carries data");
endmodule

bind first_fit_partition_allocator_core ffpa_checker u_ffpa_checker (.*);
